@@ rtl/tet_pkg.sv @@
// Shared types and codes for the timeout event table.
package tet_pkg;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_POLL   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_ENDED     = 3'd4;
  localparam logic [2:0] ST_TIMED_OUT = 3'd5;
  localparam logic [2:0] ST_NONE      = 3'd6;

  // Register map (byte address / 4)
  localparam logic REG_TIMEOUT_REASON = 1'b0;

  typedef struct packed {
    logic [15:0] code;
    logic [31:0] reference;
    logic [31:0] deadline;
    logic [7:0]  handler;
    logic [31:0] context_word;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic        scan;     // look up and close the gap at the first hit
    logic        poll;     // hit test is expiry rather than key match
    logic        add;      // append the new entry at the list end
    logic [15:0] key_code;
    logic [31:0] key_ref;
    logic [31:0] now;
    entry_t      new_entry;
  } op_t;

endpackage

@@ rtl/timeout_event_table_core.sv @@
// Top level of the timeout event table: command port, config port and cell row.
// Timing: done is registered from busy, which is registered when start is accepted.
// A new command is not accepted while busy; busy is high for the single cycle in
//   which the cell row is scanned, the first hit selected and the gap closed, or an add appended.
// Reset: list empty, time zero, timeout reason zero; slot contents are left
//   as they are and never read before written. No clearing pass.
// Results are shown for one cycle only; the receiver cannot stall.
module timeout_event_table_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [15:0] event_code,
  input  logic [31:0] reference,
  input  logic [7:0]  handler,
  input  logic [31:0] delay,
  input  logic [31:0] param,
  input  logic [31:0] end_reason,
  input  logic [15:0] elapsed,
  // result beat
  output logic        done,
  output logic [2:0]  status,
  output logic        notify,
  output logic [15:0] out_code,
  output logic [31:0] out_reference,
  output logic [7:0]  out_handler,
  output logic [31:0] out_context,
  output logic [31:0] out_reason,
  output logic [31:0] out_param,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(DEPTH + 1);

  // ---- configuration ----
  logic [31:0] timeout_reason;
  logic        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == tet_pkg::REG_TIMEOUT_REASON);
  assign prdata  = cfg_sel ? timeout_reason : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reason <= 32'd0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      timeout_reason <= pwdata;
    end
  end

  // ---- command capture ----
  // Time advances at accept of a poll, so the scan cycle sees the updated clock.
  logic              accept;
  logic [1:0]        cmd_q;
  logic [31:0]       reason_q;
  logic [31:0]       param_q;
  logic [31:0]       now_ticks;
  logic [CW-1:0]     live_count;
  tet_pkg::entry_t   new_entry;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q                  <= cmd;
      reason_q               <= end_reason;
      param_q                <= param;
      new_entry.code         <= event_code;
      new_entry.reference    <= reference;
      new_entry.handler      <= handler;
      new_entry.context_word <= param;
      new_entry.deadline     <= now_ticks + delay;
    end
  end

  // ---- cell row ----
  tet_pkg::op_t    op;
  logic            hit_chain [DEPTH+1];
  tet_pkg::entry_t sel_chain [DEPTH+1];
  tet_pkg::entry_t slot      [DEPTH];

  always_comb begin
    op.scan      = busy && (cmd_q != tet_pkg::CMD_ADD);
    op.poll      = (cmd_q == tet_pkg::CMD_POLL);
    op.add       = busy && (cmd_q == tet_pkg::CMD_ADD);
    op.key_code  = new_entry.code;
    op.key_ref   = new_entry.reference;
    op.now       = now_ticks;
    op.new_entry = new_entry;
  end

  assign hit_chain[0] = 1'b0;
  assign sel_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tet_pkg::entry_t upper;
    if (i < DEPTH - 1) begin : g_mid
      assign upper = slot[i+1];
    end else begin : g_top
      assign upper = new_entry;   // top slot shifts in don't-care data
    end

    tet_cell u_cell (
      .clk        (clk),
      .op         (op),
      .live       (CW'(i) < live_count),
      .load_here  (CW'(i) == live_count),
      .hit_in     (hit_chain[i]),
      .sel_in     (sel_chain[i]),
      .next_entry (upper),
      .hit_out    (hit_chain[i+1]),
      .sel_out    (sel_chain[i+1]),
      .entry      (slot[i])
    );
  end

  // ---- control and result ----
  logic            hit;
  logic            full;
  tet_pkg::entry_t sel;

  assign hit  = hit_chain[DEPTH];
  assign sel  = sel_chain[DEPTH];
  assign full = (live_count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      live_count <= '0;
      now_ticks  <= 32'd0;
    end else begin
      done <= busy;
      if (accept) begin
        busy <= 1'b1;
        if (cmd == tet_pkg::CMD_POLL) begin
          now_ticks <= now_ticks + 32'(elapsed);
        end
      end else begin
        busy <= 1'b0;
      end
      if (busy) begin
        if (cmd_q == tet_pkg::CMD_ADD) begin
          if (!full) begin
            live_count <= live_count + CW'(1);
          end
        end else if (hit) begin
          live_count <= live_count - CW'(1);
        end
      end
    end
  end

  // result beat payload; fields are zero unless end or poll releases an entry
  always_ff @(posedge clk) begin
    if (busy) begin
      case (cmd_q)
        tet_pkg::CMD_ADD: begin
          status <= full ? tet_pkg::ST_FULL : tet_pkg::ST_ADDED;
        end
        tet_pkg::CMD_REMOVE: begin
          status <= hit ? tet_pkg::ST_REMOVED : tet_pkg::ST_NOT_FOUND;
        end
        tet_pkg::CMD_END: begin
          status <= hit ? tet_pkg::ST_ENDED : tet_pkg::ST_NOT_FOUND;
        end
        default: begin   // poll
          status <= hit ? tet_pkg::ST_TIMED_OUT : tet_pkg::ST_NONE;
        end
      endcase
      // only end and poll report the released entry; poll reports the set reason
      if (hit && (cmd_q == tet_pkg::CMD_END || cmd_q == tet_pkg::CMD_POLL)) begin
        notify        <= (sel.handler != 8'd0);
        out_code      <= sel.code;
        out_reference <= sel.reference;
        out_handler   <= sel.handler;
        out_context   <= sel.context_word;
        out_reason    <= (cmd_q == tet_pkg::CMD_END) ? reason_q : timeout_reason;
        out_param     <= (cmd_q == tet_pkg::CMD_END) ? param_q : 32'd0;
      end else begin
        notify        <= 1'b0;
        out_code      <= '0;
        out_reference <= '0;
        out_handler   <= '0;
        out_context   <= '0;
        out_reason    <= '0;
        out_param     <= '0;
      end
    end
  end

endmodule

@@ rtl/tet_cell.sv @@
// One slot of the ordered list: hit test, first-hit select, shift-down and append load.
module tet_cell (
  input  logic            clk,
  input  tet_pkg::op_t    op,
  input  logic            live,
  input  logic            load_here,
  input  logic            hit_in,
  input  tet_pkg::entry_t sel_in,
  input  tet_pkg::entry_t next_entry,
  output logic            hit_out,
  output tet_pkg::entry_t sel_out,
  output tet_pkg::entry_t entry
);

  logic key_match;
  logic expired;
  logic match;
  logic first;

  assign key_match = (entry.code == op.key_code) && (entry.reference == op.key_ref);
  assign expired   = !(op.now < entry.deadline);
  assign match     = op.scan && live && (op.poll ? expired : key_match);
  assign first     = match && !hit_in;
  assign hit_out   = hit_in || match;
  assign sel_out   = first ? entry : sel_in;

  // from the first hit onwards each cell takes its upper neighbour
  always_ff @(posedge clk) begin
    if (op.scan && hit_out) begin
      entry <= next_entry;
    end else if (op.add && load_here) begin
      entry <= op.new_entry;
    end
  end

endmodule

@@ rtl/tet_checker.sv @@
// Port-level checks for the timeout event table, bound to the top level.
module tet_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        notify,
  input logic [15:0] out_code,
  input logic [31:0] out_reference,
  input logic [7:0]  out_handler,
  input logic [31:0] out_context,
  input logic [31:0] out_reason,
  input logic [31:0] out_param
);

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_done : assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("scan cycle not followed by a result beat");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command");

  a_status_range : assert property (@(posedge clk) disable iff (rst)
    done |-> status <= tet_pkg::ST_NONE)
    else $error("status code out of range");

  a_quiet_fields : assert property (@(posedge clk) disable iff (rst)
    done && (status == tet_pkg::ST_ADDED || status == tet_pkg::ST_FULL ||
             status == tet_pkg::ST_NOT_FOUND || status == tet_pkg::ST_REMOVED ||
             status == tet_pkg::ST_NONE)
    |-> !notify && out_code == 16'd0 && out_reference == 32'd0 &&
        out_handler == 8'd0 && out_context == 32'd0 &&
        out_reason == 32'd0 && out_param == 32'd0)
    else $error("released-entry fields set on a non-release result");

endmodule

bind timeout_event_table_core tet_checker u_tet_checker (.*);
